// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define VDC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define VDC_NEVER(name, clk, rst_n, expr, msg) \
  `VDC_ASSERT(name, clk, rst_n, !(expr), msg)

`endif

// ----- rtl/core/vdc_pkg.sv -----
// Shared types, constants and coefficient table of the velocity/density converter.
package vdc_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS      = 12;
  localparam int COEF_FRAC_BITS = 20;
  localparam int RND_SHIFT      = COEF_FRAC_BITS - FRAC_BITS;

  localparam int VEL_W  = 16;
  localparam int OUT_W  = 24;
  localparam int ACC_W  = 48;
  localparam int PROD_W = ACC_W + VEL_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = ACC_W + 1;

  localparam int NUM_CELLS  = 5;
  localparam int CELL_IDX_W = 3;

  // Mode codes
  localparam logic [1:0] MODE_VP_FROM_VS  = 2'd0;
  localparam logic [1:0] MODE_RHO_FROM_VS = 2'd1;
  localparam logic [1:0] MODE_RHO_FROM_VP = 2'd2;
  localparam logic [1:0] MODE_RHO_LINEAR  = 2'd3;

  // Rounding offsets and limits
  localparam logic signed [PROD_W-1:0] HALF_PROD =
    PROD_W'((64'd1 << FRAC_BITS) >> 1);
  localparam logic signed [RND_W-1:0] HALF_OUT =
    RND_W'((64'd1 << RND_SHIFT) >> 1);
  localparam logic signed [SUM_W-1:0] ACC_LIM_HI = 66'sd70368744177664;
  localparam logic signed [SUM_W-1:0] ACC_LIM_LO = -ACC_LIM_HI;
  localparam logic signed [RND_W-1:0] OUT_MAX = 49'sd8388607;
  localparam logic signed [RND_W-1:0] OUT_MIN = -49'sd8388608;

  // Coefficient magnitudes, millionths rounded half up to COEF_FRAC_BITS
  localparam logic signed [ACC_W-1:0] C_VS_VP_4 =
    ACC_W'(((64'd25100 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VS_VP_3 =
    ACC_W'(((64'd268300 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VS_VP_2 =
    ACC_W'(((64'd820600 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VS_VP_1 =
    ACC_W'(((64'd2094700 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VS_VP_0 =
    ACC_W'(((64'd940900 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);

  localparam logic signed [ACC_W-1:0] C_VS_RHO_4 =
    ACC_W'(((64'd16560 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VS_RHO_3 =
    ACC_W'(((64'd206730 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VS_RHO_2 =
    ACC_W'(((64'd836680 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VS_RHO_1 =
    ACC_W'(((64'd1532010 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VS_RHO_0 =
    ACC_W'(((64'd1226790 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);

  localparam logic signed [ACC_W-1:0] C_VP_RHO_5 =
    ACC_W'(((64'd106 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VP_RHO_4 =
    ACC_W'(((64'd4300 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VP_RHO_3 =
    ACC_W'(((64'd67100 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VP_RHO_2 =
    ACC_W'(((64'd472100 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);
  localparam logic signed [ACC_W-1:0] C_VP_RHO_1 =
    ACC_W'(((64'd1661200 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);

  // Linear law: 2.42 + (2/9) v
  localparam logic signed [ACC_W-1:0] C_LIN_1 =
    ACC_W'(((64'd2 << (COEF_FRAC_BITS + 1)) + 64'd9) / 64'd18);
  localparam logic signed [ACC_W-1:0] C_LIN_0 =
    ACC_W'(((64'd2420000 << (COEF_FRAC_BITS + 1)) + 64'd1000000) / 64'd2000000);

  // Item travelling down the cell row
  typedef struct packed {
    logic                    valid;
    logic [1:0]              mode;
    logic [VEL_W-1:0]        vel;
    logic signed [ACC_W-1:0] acc;
  } vdc_stage_t;

  // Coefficient of Horner step idx (0 = highest degree, degree 5)
  function automatic logic signed [ACC_W-1:0] coef_sel(input logic [1:0] mode,
                                                       input logic [CELL_IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] c;
    c = '0;
    unique case (mode)
      MODE_VP_FROM_VS: begin
        case (idx)
          3'd1:    c = -C_VS_VP_4;
          3'd2:    c = C_VS_VP_3;
          3'd3:    c = -C_VS_VP_2;
          3'd4:    c = C_VS_VP_1;
          3'd5:    c = C_VS_VP_0;
          default: c = '0;
        endcase
      end
      MODE_RHO_FROM_VS: begin
        case (idx)
          3'd1:    c = -C_VS_RHO_4;
          3'd2:    c = C_VS_RHO_3;
          3'd3:    c = -C_VS_RHO_2;
          3'd4:    c = C_VS_RHO_1;
          3'd5:    c = C_VS_RHO_0;
          default: c = '0;
        endcase
      end
      MODE_RHO_FROM_VP: begin
        case (idx)
          3'd0:    c = C_VP_RHO_5;
          3'd1:    c = -C_VP_RHO_4;
          3'd2:    c = C_VP_RHO_3;
          3'd3:    c = -C_VP_RHO_2;
          3'd4:    c = C_VP_RHO_1;
          default: c = '0;
        endcase
      end
      MODE_RHO_LINEAR: begin
        case (idx)
          3'd4:    c = C_LIN_1;
          3'd5:    c = C_LIN_0;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/velocity_density_conversion.sv -----
// Pipeline from start to done_o: five Horner cells and one rounding stage, all registered.
// Throughput: one item per cycle; busy stays low, the cell row never stalls.
// Each cell holds one Horner step of one item and passes it on every cycle.
// Reset (rst_ni low, asynchronous) clears all valid flags; items in flight are dropped.
// Results appear for one cycle with done_o and cannot be held off by the receiver.
module velocity_density_conversion (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       mode_i,
  input  logic [vdc_pkg::VEL_W-1:0]        velocity_i,
  output logic                             done_o,
  output logic signed [vdc_pkg::OUT_W-1:0] result_value_o,
  output logic                             saturated_o
);
  import vdc_pkg::*;

  vdc_stage_t              stg [0:NUM_CELLS];
  logic signed [ACC_W-1:0] cell_coef [1:NUM_CELLS];

  // Never stalls
  assign busy = 1'b0;

  // Entry: the leading coefficient seeds the accumulator
  assign stg[0] = '{valid: start & ~busy,
                    mode:  mode_i,
                    vel:   velocity_i,
                    acc:   coef_sel(mode_i, '0)};

  // Row of Horner cells
  for (genvar k = 1; k <= NUM_CELLS; k++) begin : g_cell
    assign cell_coef[k] = coef_sel(stg[k-1].mode, CELL_IDX_W'(k));

    vdc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stg[k-1]),
      .coef_i  (cell_coef[k]),
      .stage_o (stg[k])
    );
  end

  // Output rounding and saturation
  vdc_round u_round (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (stg[NUM_CELLS]),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .saturated_o    (saturated_o)
  );

endmodule

// ----- rtl/core/vdc_cell.sv -----
// One Horner cell: acc <- clip(rnd(acc * v) + coef), registered, handed to the next cell.
module vdc_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vdc_pkg::vdc_stage_t              stage_i,
  input  logic signed [vdc_pkg::ACC_W-1:0] coef_i,
  output vdc_pkg::vdc_stage_t              stage_o
);
  import vdc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [PROD_W-1:0] prod_shf;
  logic signed [SUM_W-1:0]  sum;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     valid_q;
  logic [1:0]               mode_q;
  logic [VEL_W-1:0]         vel_q;

  // Multiply, round half up, add the coefficient
  always_comb begin
    prod     = stage_i.acc * $signed({1'b0, stage_i.vel});
    prod_rnd = prod + HALF_PROD;
    prod_shf = prod_rnd >>> FRAC_BITS;
    sum      = $signed({prod_shf[PROD_W-1], prod_shf})
             + $signed({{(SUM_W-ACC_W){coef_i[ACC_W-1]}}, coef_i});
    // keep the accumulator within +-2^46
    if (sum > ACC_LIM_HI) begin
      acc_d = ACC_W'(ACC_LIM_HI);
    end else if (sum < ACC_LIM_LO) begin
      acc_d = ACC_W'(ACC_LIM_LO);
    end else begin
      acc_d = ACC_W'(sum);
    end
  end

  // Item valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    mode_q <= stage_i.mode;
    vel_q  <= stage_i.vel;
    acc_q  <= acc_d;
  end

  assign stage_o = '{valid: valid_q, mode: mode_q, vel: vel_q, acc: acc_q};

endmodule

// ----- rtl/core/vdc_round.sv -----
// Output stage: rounds the accumulator to the output format and saturates it.
module vdc_round (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vdc_pkg::vdc_stage_t              stage_i,
  output logic                             done_o,
  output logic signed [vdc_pkg::OUT_W-1:0] result_value_o,
  output logic                             saturated_o
);
  import vdc_pkg::*;

  logic signed [RND_W-1:0] acc_rnd;
  logic signed [RND_W-1:0] res;
  logic signed [OUT_W-1:0] res_d;
  logic                    sat_d;
  logic                    done_q;
  logic signed [OUT_W-1:0] res_q;
  logic                    sat_q;

  // Drop the extra coefficient fraction bits, then clip
  always_comb begin
    acc_rnd = $signed({stage_i.acc[ACC_W-1], stage_i.acc}) + HALF_OUT;
    res     = acc_rnd >>> RND_SHIFT;
    if (res > OUT_MAX) begin
      res_d = OUT_W'(OUT_MAX);
      sat_d = 1'b1;
    end else if (res < OUT_MIN) begin
      res_d = OUT_W'(OUT_MIN);
      sat_d = 1'b1;
    end else begin
      res_d = OUT_W'(res);
      sat_d = 1'b0;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage_i.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign saturated_o    = sat_q;

endmodule

// ----- rtl/core/vdc_checker.sv -----
// Port-level checker for the velocity/density converter, bound to the top level.
`include "assert_macros.svh"

module vdc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic [1:0]                       mode_i,
  input logic                             done_o,
  input logic signed [vdc_pkg::OUT_W-1:0] result_value_o,
  input logic                             saturated_o
);
  import vdc_pkg::*;

  // Pipeline never pushes back
  `VDC_NEVER(a_never_busy, clk_i, rst_ni, busy, "busy raised")

  // Every accepted item yields a result after the cell row and the rounding stage
  `VDC_ASSERT(a_item_to_result, clk_i, rst_ni, start && !busy |-> ##6 done_o, "result missing")

  // No result without an item that entered the cell row ahead of it
  `VDC_ASSERT(a_result_has_item, clk_i, rst_ni, done_o |-> $past(start, 6), "spurious result")

  // A clipped result sits at one of the range limits
  `VDC_ASSERT(a_sat_at_limit, clk_i, rst_ni, done_o && saturated_o |-> result_value_o == OUT_W'(OUT_MAX) || result_value_o == OUT_W'(OUT_MIN), "saturated off limit")

  // The linear law stays well inside the output range
  `VDC_ASSERT(a_linear_no_sat, clk_i, rst_ni, start && !busy && mode_i == MODE_RHO_LINEAR |-> ##6 !saturated_o, "linear law clipped")

endmodule

bind velocity_density_conversion vdc_checker u_vdc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .mode_i         (mode_i),
  .done_o         (done_o),
  .result_value_o (result_value_o),
  .saturated_o    (saturated_o)
);
